// ===== hdl/cartesian_polar_converter_defines.svh =====
// ---------------------------------------------------------------------------
// Cartesian/polar converter assertion macros
// Shared concurrent check macros, clocked on clk and held off during rst_n.
// ---------------------------------------------------------------------------
`ifndef CARTESIAN_POLAR_CONVERTER_DEFINES_SVH
`define CARTESIAN_POLAR_CONVERTER_DEFINES_SVH

// Same-cycle implication check.
`define CCV_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define CCV_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ccv_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccv_pkg
// Types, fixed-point constants and the arctangent table of the converter.
// ---------------------------------------------------------------------------
package ccv_pkg;

  // angle accumulator: Q.30 radians, room for pi plus the sum of all steps
  localparam int ZW = 35;
  // rounded coordinate width after gain compensation
  localparam int QW = 20;
  localparam int ATAN_ENTRIES = 24;

  localparam logic ACT_TO_POLAR = 1'b0;
  localparam logic ACT_TO_CART  = 1'b1;

  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [15:0]   PI_Q13      = 16'sd25736;
  localparam longint unsigned      GAIN_BASE_Q24 = 64'd10188014;
  localparam int                   GAIN_FRAC   = 24;

  typedef struct packed {
    logic valid;
    logic action;
    logic zero;    // vectoring request on the origin
  } ccv_ctl_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:       v = 35'sh0_3243F6A8;
      1:       v = 35'sh0_1DAC6705;
      2:       v = 35'sh0_0FADBAFC;
      3:       v = 35'sh0_07F56EA6;
      4:       v = 35'sh0_03FEAB76;
      5:       v = 35'sh0_01FFD55B;
      6:       v = 35'sh0_00FFFAAA;
      7:       v = 35'sh0_007FFF55;
      8:       v = 35'sh0_003FFFEA;
      9:       v = 35'sh0_001FFFFD;
      10:      v = 35'sh0_000FFFFF;
      11:      v = 35'sh0_0007FFFF;
      12:      v = 35'sh0_0003FFFF;
      13:      v = 35'sh0_0001FFFF;
      14:      v = 35'sh0_0000FFFF;
      15:      v = 35'sh0_00007FFF;
      16:      v = 35'sh0_00003FFF;
      17:      v = 35'sh0_00001FFF;
      18:      v = 35'sh0_00000FFF;
      19:      v = 35'sh0_000007FF;
      20:      v = 35'sh0_000003FF;
      21:      v = 35'sh0_000001FF;
      22:      v = 35'sh0_000000FF;
      23:      v = 35'sh0_0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/ccv_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccv_in_if / ccv_out_if
// Valid/ready channels for converter requests and results.
// ---------------------------------------------------------------------------
interface ccv_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] x_in;
  logic signed [15:0] y_in;
  logic        [14:0] radius_in;
  logic signed [15:0] angle_in;

  modport source (output valid, action, x_in, y_in, radius_in, angle_in, input ready);
  modport sink   (input valid, action, x_in, y_in, radius_in, angle_in, output ready);
endinterface

interface ccv_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] radius_out;
  logic signed [15:0] angle_out;
  logic signed [15:0] x_out;
  logic signed [15:0] y_out;

  modport source (output valid, radius_out, angle_out, x_out, y_out, input ready);
  modport sink   (input valid, radius_out, angle_out, x_out, y_out, output ready);
endinterface

// ===== hdl/cartesian_polar_converter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cartesian_polar_converter
// Pipelined CORDIC converter between Cartesian and polar coordinates.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : requests. action 0 takes x_in/y_in (Q.12) and returns radius_out
//            (Q.12) and angle_out (Q.13 radians); action 1 takes radius_in and
//            angle_in and returns x_out/y_out. Unused result fields are zero.
//   out_ch : one result per request, in request order.
// Stages: input stage, one stage per micro-rotation, multiply stage, and
//   the round/saturate stage that holds the output register.
// Throughput: one request per cycle unless the receiver stalls; every stage
// is a single register. Each stage holds its item while the next stage is
// full and stalled, so a stalled receiver backs up the pipe one stage at a
// time and empty stages keep taking requests until the pipe is full.
// Nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; no warm-up needed.
// ---------------------------------------------------------------------------
`include "cartesian_polar_converter_defines.svh"

module cartesian_polar_converter #(
  parameter int ITERATIONS = 16,
  parameter int DATA_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ccv_in_if.sink    in_ch,
  ccv_out_if.source out_ch
);
  import ccv_pkg::*;

  localparam int N  = (ITERATIONS < ATAN_ENTRIES) ? ITERATIONS : ATAN_ENTRIES;
  // datapath width: scaled input, negation and CORDIC growth
  localparam int CW = DATA_WIDTH + 7;

  ccv_ctl_t             ctl [N+1];
  logic signed [CW-1:0] xv  [N+1];
  logic signed [CW-1:0] yv  [N+1];
  logic signed [ZW-1:0] zv  [N+1];
  logic                 rdy [N+1];

  ccv_pre #(
    .DATA_WIDTH (DATA_WIDTH),
    .CW         (CW)
  ) u_pre (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .ctl_o   (ctl[0]),
    .x_o     (xv[0]),
    .y_o     (yv[0]),
    .z_o     (zv[0]),
    .ready_i (rdy[0])
  );

  for (genvar k = 0; k < N; k++) begin : g_stage
    ccv_stage #(
      .CW    (CW),
      .STAGE (k)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl[k]),
      .x_i     (xv[k]),
      .y_i     (yv[k]),
      .z_i     (zv[k]),
      .ready_o (rdy[k]),
      .ctl_o   (ctl[k+1]),
      .x_o     (xv[k+1]),
      .y_o     (yv[k+1]),
      .z_o     (zv[k+1]),
      .ready_i (rdy[k+1])
    );
  end

  ccv_post #(
    .DATA_WIDTH (DATA_WIDTH),
    .ITERATIONS (ITERATIONS),
    .CW         (CW)
  ) u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl[N]),
    .x_i     (xv[N]),
    .y_i     (yv[N]),
    .z_i     (zv[N]),
    .ready_o (rdy[N]),
    .out_ch  (out_ch)
  );

  // a polar result never carries Cartesian fields
  `CCV_CHECK_NOW(a_polar_excl,
    out_ch.valid && (out_ch.radius_out != 16'd0 || out_ch.angle_out != 16'sd0),
    out_ch.x_out == 16'sd0 && out_ch.y_out == 16'sd0, "polar result with nonzero x/y")
  // angle stays within +-pi
  `CCV_CHECK_NOW(a_angle_rng, out_ch.valid,
    out_ch.angle_out <= PI_Q13 && out_ch.angle_out >= -PI_Q13, "angle_out beyond pi")
  // a draining output must open the whole ready chain
  `CCV_CHECK_NOW(a_ready_chain, out_ch.ready, in_ch.ready,
    "ready chain blocked while output drains")
  // a stalled result holds still until taken
  `CCV_CHECK_NEXT(a_out_hold, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(out_ch.radius_out) && $stable(out_ch.angle_out) &&
    $stable(out_ch.x_out) && $stable(out_ch.y_out), "result changed while stalled")

endmodule

// ===== hdl/ccv_pre.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccv_pre
// Input stage: scales the request, folds it into the right half plane and
// registers the starting vector and angle.
// ---------------------------------------------------------------------------
module ccv_pre #(
  parameter int DATA_WIDTH = 16,
  parameter int CW         = 23
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ccv_in_if.sink                          in_ch,
  output ccv_pkg::ccv_ctl_t               ctl_o,
  output logic signed [CW-1:0]            x_o,
  output logic signed [CW-1:0]            y_o,
  output logic signed [ccv_pkg::ZW-1:0]   z_o,
  input  logic                            ready_i
);
  import ccv_pkg::*;

  localparam int SCL = DATA_WIDTH - 12;

  ccv_ctl_t             ctl_r;
  logic signed [CW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic                 zero_nxt;

  logic signed [CW-1:0] xs, ys, rs;
  logic signed [15:0]   a_sat;
  logic signed [ZW-1:0] az;

  always_comb begin
    xs = $signed({{(CW-16){in_ch.x_in[15]}}, in_ch.x_in}) <<< SCL;
    ys = $signed({{(CW-16){in_ch.y_in[15]}}, in_ch.y_in}) <<< SCL;
    rs = $signed({{(CW-15){1'b0}}, in_ch.radius_in}) <<< SCL;

    if (in_ch.angle_in > PI_Q13) begin
      a_sat = PI_Q13;
    end else if (in_ch.angle_in < -PI_Q13) begin
      a_sat = -PI_Q13;
    end else begin
      a_sat = in_ch.angle_in;
    end
    az = $signed({{(ZW-16){a_sat[15]}}, a_sat}) <<< 17;

    zero_nxt = (in_ch.x_in == 16'sd0) && (in_ch.y_in == 16'sd0);
    if (in_ch.action == ACT_TO_POLAR) begin
      if (in_ch.x_in < 16'sd0) begin
        x_nxt = -xs;
        y_nxt = -ys;
        z_nxt = (in_ch.y_in >= 16'sd0) ? PI_Q30 : -PI_Q30;
      end else begin
        x_nxt = xs;
        y_nxt = ys;
        z_nxt = '0;
      end
    end else begin
      // fold angles beyond +-pi/2 back by pi and flip the start vector
      y_nxt = '0;
      if (az > HALF_PI_Q30) begin
        z_nxt = az - PI_Q30;
        x_nxt = -rs;
      end else if (az < -HALF_PI_Q30) begin
        z_nxt = az + PI_Q30;
        x_nxt = -rs;
      end else begin
        z_nxt = az;
        x_nxt = rs;
      end
    end
  end

  assign in_ch.ready = !ctl_r.valid || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (in_ch.ready) begin
      ctl_r.valid <= in_ch.valid;
      if (in_ch.valid) begin
        ctl_r.action <= in_ch.action;
        ctl_r.zero   <= zero_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

// ===== hdl/ccv_stage.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccv_stage
// One registered CORDIC micro-rotation; vectoring or rotation per request.
// ---------------------------------------------------------------------------
module ccv_stage #(
  parameter int CW    = 23,
  parameter int STAGE = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ccv_pkg::ccv_ctl_t               ctl_i,
  input  logic signed [CW-1:0]            x_i,
  input  logic signed [CW-1:0]            y_i,
  input  logic signed [ccv_pkg::ZW-1:0]   z_i,
  output logic                            ready_o,
  output ccv_pkg::ccv_ctl_t               ctl_o,
  output logic signed [CW-1:0]            x_o,
  output logic signed [CW-1:0]            y_o,
  output logic signed [ccv_pkg::ZW-1:0]   z_o,
  input  logic                            ready_i
);
  import ccv_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = atan_q30(STAGE);

  ccv_ctl_t             ctl_r;
  logic signed [CW-1:0] x_r, y_r, x_nxt, y_nxt, xsh, ysh;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic                 ccw;

  always_comb begin
    xsh = x_i >>> STAGE;
    ysh = y_i >>> STAGE;
    // rotation drives z to zero, vectoring drives y to zero
    ccw = (ctl_i.action == ACT_TO_CART) ? (z_i >= 0) : (y_i < 0);
    if (ccw) begin
      x_nxt = x_i - ysh;
      y_nxt = y_i + xsh;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + ysh;
      y_nxt = y_i - xsh;
      z_nxt = z_i + ATAN;
    end
  end

  assign ready_o = !ctl_r.valid || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (ready_o) begin
      ctl_r.valid <= ctl_i.valid;
      if (ctl_i.valid) begin
        ctl_r.action <= ctl_i.action;
        ctl_r.zero   <= ctl_i.zero;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && ctl_i.valid) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

// ===== hdl/ccv_post.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccv_post
// Gain compensation and output rounding: a split multiply stage, then the
// add, round, saturate stage that forms the output register.
// ---------------------------------------------------------------------------
module ccv_post #(
  parameter int DATA_WIDTH = 16,
  parameter int ITERATIONS = 16,
  parameter int CW         = 23
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ccv_pkg::ccv_ctl_t               ctl_i,
  input  logic signed [CW-1:0]            x_i,
  input  logic signed [CW-1:0]            y_i,
  input  logic signed [ccv_pkg::ZW-1:0]   z_i,
  output logic                            ready_o,
  ccv_out_if.source                       out_ch
);
  import ccv_pkg::*;

  localparam int GSH = 2 * ITERATIONS;
  localparam longint unsigned GCORR =
    (2 * GAIN_BASE_Q24 / 3 + (64'd1 << (GSH - 1))) >> GSH;
  localparam logic [23:0] GAIN = 24'(GAIN_BASE_Q24 + GCORR);

  localparam int HW = CW - 16 + 25;              // high partial product
  localparam int LW = 42;                        // low partial product
  localparam int PW = CW + 25;                   // full product
  localparam int SH = GAIN_FRAC + DATA_WIDTH - 12;
  localparam logic signed [PW-1:0] RND = $signed(PW'(1)) <<< (SH - 1);

  // stage 1: partial products
  ccv_ctl_t             ctl1_r;
  logic signed [HW-1:0] px_hi_r, py_hi_r, px_hi_nxt, py_hi_nxt;
  logic signed [LW-1:0] px_lo_r, py_lo_r, px_lo_nxt, py_lo_nxt;
  logic signed [ZW-1:0] z1_r;
  logic                 ready1;

  // stage 2: output register
  logic                 vld_r;
  logic        [15:0]   radius_r, radius_nxt;
  logic signed [15:0]   angle_r, angle_nxt, x_r, x_nxt, y_r, y_nxt;
  logic                 ready2;

  logic signed [PW-1:0] sx, sy;
  logic signed [QW-1:0] qx, qy;
  logic signed [ZW-1:0] za;
  logic signed [ZW-18:0] qa;

  always_comb begin
    px_hi_nxt = $signed(x_i[CW-1:16]) * $signed({1'b0, GAIN});
    py_hi_nxt = $signed(y_i[CW-1:16]) * $signed({1'b0, GAIN});
    px_lo_nxt = $signed({1'b0, x_i[15:0]}) * $signed({1'b0, GAIN});
    py_lo_nxt = $signed({1'b0, y_i[15:0]}) * $signed({1'b0, GAIN});
  end

  assign ready2  = !vld_r || out_ch.ready;
  assign ready1  = !ctl1_r.valid || ready2;
  assign ready_o = ready1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else if (ready1) begin
      ctl1_r.valid <= ctl_i.valid;
      if (ctl_i.valid) begin
        ctl1_r.action <= ctl_i.action;
        ctl1_r.zero   <= ctl_i.zero;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && ctl_i.valid) begin
      px_hi_r <= px_hi_nxt;
      py_hi_r <= py_hi_nxt;
      px_lo_r <= px_lo_nxt;
      py_lo_r <= py_lo_nxt;
      z1_r    <= z_i;
    end
  end

  always_comb begin
    sx = $signed({px_hi_r, 16'h0000}) + $signed({{(PW-LW){px_lo_r[LW-1]}}, px_lo_r}) + RND;
    sy = $signed({py_hi_r, 16'h0000}) + $signed({{(PW-LW){py_lo_r[LW-1]}}, py_lo_r}) + RND;
    qx = $signed(sx[PW-1:SH]);
    qy = $signed(sy[PW-1:SH]);
    za = z1_r + ZW'(65536);
    qa = $signed(za[ZW-1:17]);

    radius_nxt = '0;
    angle_nxt  = '0;
    x_nxt      = '0;
    y_nxt      = '0;
    if (ctl1_r.action == ACT_TO_POLAR) begin
      if (!ctl1_r.zero) begin
        if (qx < 0) begin
          radius_nxt = '0;
        end else if (qx > QW'(65535)) begin
          radius_nxt = 16'hFFFF;
        end else begin
          radius_nxt = qx[15:0];
        end
        if (qa > (ZW-17)'(PI_Q13)) begin
          angle_nxt = PI_Q13;
        end else if (qa < -(ZW-17)'(PI_Q13)) begin
          angle_nxt = -PI_Q13;
        end else begin
          angle_nxt = qa[15:0];
        end
      end
    end else begin
      if (qx > QW'(32767)) begin
        x_nxt = 16'sh7FFF;
      end else if (qx < -QW'(32768)) begin
        x_nxt = -16'sh8000;
      end else begin
        x_nxt = qx[15:0];
      end
      if (qy > QW'(32767)) begin
        y_nxt = 16'sh7FFF;
      end else if (qy < -QW'(32768)) begin
        y_nxt = -16'sh8000;
      end else begin
        y_nxt = qy[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready2) begin
      vld_r <= ctl1_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && ctl1_r.valid) begin
      radius_r <= radius_nxt;
      angle_r  <= angle_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
    end
  end

  assign out_ch.valid      = vld_r;
  assign out_ch.radius_out = radius_r;
  assign out_ch.angle_out  = angle_r;
  assign out_ch.x_out      = x_r;
  assign out_ch.y_out      = y_r;

endmodule
